// ===== rtl/sotfl_pkg.sv =====
// ----------------------------------------------------------------------------
// sotfl_pkg
// Shared types and constants of the sorted offset table floor lookup core.
// ----------------------------------------------------------------------------
package sotfl_pkg;

    localparam int DEF_TABLE_DEPTH = 2048;
    localparam int DEF_INFO_WIDTH  = 32;

    localparam int KEY_W       = 32;
    localparam int IN_INFO_W   = 32;
    localparam int HIT_IDX_W   = 11;
    localparam int HIT_INFO_W  = 32;
    localparam int TOTAL_W     = 12;

    typedef enum logic [1:0] {
        CMD_ADD    = 2'd0,
        CMD_SEAL   = 2'd1,
        CMD_LOOKUP = 2'd2,
        CMD_CLEAR  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NOTFOUND = 2'd1,
        ST_FULL     = 2'd2,
        ST_UNSEALED = 2'd3
    } status_t;

    typedef struct packed {
        cmd_t                   cmd;
        logic [KEY_W-1:0]       key_offset;
        logic [IN_INFO_W-1:0]   entry_info;
    } in_word_t;

    typedef struct packed {
        status_t                status;
        logic [HIT_IDX_W-1:0]   hit_index;
        logic [KEY_W-1:0]       hit_offset;
        logic [HIT_INFO_W-1:0]  hit_info;
        logic [TOTAL_W-1:0]     entry_total;
    } out_word_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_CAPTURE,
        OP_APPEND,
        OP_CLEAR,
        OP_SEAL_INIT,
        OP_SORT_RD_I,
        OP_SORT_CAP,
        OP_SORT_RD_J,
        OP_SORT_SHIFT,
        OP_SORT_PLACE,
        OP_SEAL_DONE,
        OP_LK_UNSEALED,
        OP_LK_INIT,
        OP_LK_RD_MID,
        OP_LK_CMP,
        OP_LK_FIN_RD
    } dp_op_t;

    // The final lookup step is flagged by lk_hit or lk_miss, not by an op code
    typedef struct packed {
        dp_op_t op;
        logic   lk_hit;
        logic   lk_miss;
    } dp_cmd_t;

    typedef struct packed {
        logic sealed;
        logic hint_valid;
        logic i_lt_fill;
        logic j_zero;
        logic shift;
        logic lo_lt_hi;
        logic lo_zero;
    } dp_status_t;

endpackage

// ===== rtl/sorted_offset_table_floor_lookup_core.sv =====
// ----------------------------------------------------------------------------
// sorted_offset_table_floor_lookup_core
// Offset table with append, stable sort, floor lookup and clear.
// ----------------------------------------------------------------------------
// A word is taken when start is high and busy is low; its result shows on
// result for the single cycle in which done is high and must be captured then,
// since the block cannot be held off. A lookup is a binary search that probes
// the table through its one read port. Seal is an in-place insertion sort
// through the same read port.
module sorted_offset_table_floor_lookup_core
    import sotfl_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
    parameter int INFO_WIDTH  = DEF_INFO_WIDTH
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    input  in_word_t  request,
    output logic      done,
    output out_word_t result
);

    dp_cmd_t    ctl;
    dp_status_t stat;

    sotfl_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .cmd   (request.cmd),
        .stat  (stat),
        .ctl   (ctl),
        .busy  (busy),
        .done  (done)
    );

    sotfl_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .INFO_WIDTH  (INFO_WIDTH)
    ) u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (ctl),
        .request (request),
        .stat    (stat),
        .result  (result)
    );

endmodule

// ===== rtl/sotfl_ram.sv =====
// ----------------------------------------------------------------------------
// sotfl_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module sotfl_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 2048,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/sotfl_datapath.sv =====
// ----------------------------------------------------------------------------
// sotfl_datapath
// Table storage, sort and search registers, and the result word.
// ----------------------------------------------------------------------------
module sotfl_datapath
    import sotfl_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
    parameter int INFO_WIDTH  = DEF_INFO_WIDTH
) (
    input  logic       clk,
    input  logic       rst_n,
    input  dp_cmd_t    ctl,
    input  in_word_t   request,
    output dp_status_t stat,
    output out_word_t  result
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    logic [CNT_W-1:0]      fill_reg, fill_next;
    logic                  sealed_reg, sealed_next;
    logic [IDX_W-1:0]      hint_reg, hint_next;
    logic [CNT_W-1:0]      i_reg, j_reg, lo_reg, hi_reg, p_reg;
    logic [KEY_W-1:0]      key_reg;
    logic [INFO_WIDTH-1:0] info_reg;
    logic [KEY_W-1:0]      ins_off_reg;
    logic [INFO_WIDTH-1:0] ins_info_reg;
    status_t               status_reg;
    logic [HIT_IDX_W-1:0]  idx_reg;
    logic [KEY_W-1:0]      off_reg;
    logic [HIT_INFO_W-1:0] hinfo_reg;

    logic                  we;
    logic [IDX_W-1:0]      waddr, raddr;
    logic [KEY_W-1:0]      wdata_off, rdata_off;
    logic [INFO_WIDTH-1:0] wdata_info, rdata_info;
    logic [CNT_W-1:0]      mid, lo_m1, j_m1;
    logic                  full;

    assign mid   = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign lo_m1 = lo_reg - CNT_W'(1);
    assign j_m1  = j_reg - CNT_W'(1);
    assign full  = (fill_reg == CNT_W'(TABLE_DEPTH));

    sotfl_ram #(.WIDTH(KEY_W), .DEPTH(TABLE_DEPTH)) u_off_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata_off),
        .raddr (raddr),
        .rdata (rdata_off)
    );

    sotfl_ram #(.WIDTH(INFO_WIDTH), .DEPTH(TABLE_DEPTH)) u_info_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata_info),
        .raddr (raddr),
        .rdata (rdata_info)
    );

    always_comb
    begin
        we         = 1'b0;
        waddr      = j_reg[IDX_W-1:0];
        wdata_off  = ins_off_reg;
        wdata_info = ins_info_reg;
        raddr      = '0;
        case (ctl.op)
            OP_APPEND:
            begin
                we         = !full;
                waddr      = fill_reg[IDX_W-1:0];
                wdata_off  = key_reg;
                wdata_info = info_reg;
            end
            OP_SORT_SHIFT:
            begin
                we         = 1'b1;
                wdata_off  = rdata_off;
                wdata_info = rdata_info;
            end
            OP_SORT_PLACE: we = 1'b1;
            OP_SORT_RD_I:  raddr = i_reg[IDX_W-1:0];
            OP_SORT_RD_J:  raddr = j_m1[IDX_W-1:0];
            OP_LK_INIT:    raddr = hint_reg;
            OP_LK_RD_MID:  raddr = mid[IDX_W-1:0];
            OP_LK_FIN_RD:  raddr = lo_m1[IDX_W-1:0];
            default:       raddr = '0;
        endcase
    end

    always_comb
    begin
        fill_next   = fill_reg;
        sealed_next = sealed_reg;
        hint_next   = hint_reg;
        case (ctl.op)
            OP_APPEND:
            begin
                if (!full)
                begin
                    fill_next   = fill_reg + CNT_W'(1);
                    sealed_next = 1'b0;
                end
            end
            OP_CLEAR:
            begin
                fill_next   = '0;
                sealed_next = 1'b0;
                hint_next   = '0;
            end
            OP_SEAL_DONE:
            begin
                sealed_next = 1'b1;
                if (CNT_W'(hint_reg) >= fill_reg)
                begin
                    hint_next = '0;
                end
            end
            default: ;
        endcase
        if (ctl.lk_hit)
        begin
            hint_next = lo_m1[IDX_W-1:0];
        end
        if (ctl.lk_miss)
        begin
            hint_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg   <= '0;
            sealed_reg <= 1'b0;
            hint_reg   <= '0;
        end
        else
        begin
            fill_reg   <= fill_next;
            sealed_reg <= sealed_next;
            hint_reg   <= hint_next;
        end
    end

    always_ff @(posedge clk)
    begin
        case (ctl.op)
            OP_CAPTURE:
            begin
                key_reg  <= request.key_offset;
                info_reg <= INFO_WIDTH'(request.entry_info);
            end
            OP_SEAL_INIT: i_reg <= CNT_W'(1);
            OP_SORT_CAP:
            begin
                ins_off_reg  <= rdata_off;
                ins_info_reg <= rdata_info;
                j_reg        <= i_reg;
            end
            OP_SORT_SHIFT: j_reg <= j_m1;
            OP_SORT_PLACE: i_reg <= i_reg + CNT_W'(1);
            OP_LK_INIT:
            begin
                lo_reg <= '0;
                hi_reg <= fill_reg;
                p_reg  <= CNT_W'(hint_reg);
            end
            OP_LK_RD_MID: p_reg <= mid;
            OP_LK_CMP:
            begin
                if (rdata_off <= key_reg)
                begin
                    lo_reg <= p_reg + CNT_W'(1);
                end
                else
                begin
                    hi_reg <= p_reg;
                end
            end
            default: ;
        endcase

        if (ctl.op == OP_APPEND || ctl.op == OP_CLEAR || ctl.op == OP_SEAL_DONE ||
            ctl.op == OP_LK_UNSEALED || ctl.lk_miss)
        begin
            idx_reg   <= '0;
            off_reg   <= '0;
            hinfo_reg <= '0;
            if (ctl.op == OP_APPEND && full)
            begin
                status_reg <= ST_FULL;
            end
            else if (ctl.op == OP_LK_UNSEALED)
            begin
                status_reg <= ST_UNSEALED;
            end
            else if (ctl.lk_miss)
            begin
                status_reg <= ST_NOTFOUND;
            end
            else
            begin
                status_reg <= ST_OK;
            end
        end
        if (ctl.lk_hit)
        begin
            status_reg <= ST_OK;
            idx_reg    <= HIT_IDX_W'(lo_m1);
            off_reg    <= rdata_off;
            hinfo_reg  <= HIT_INFO_W'(rdata_info);
        end
    end

    assign stat.sealed     = sealed_reg;
    assign stat.hint_valid = (CNT_W'(hint_reg) < fill_reg);
    assign stat.i_lt_fill  = (i_reg < fill_reg);
    assign stat.j_zero     = (j_reg == '0);
    assign stat.shift      = (rdata_off > ins_off_reg);
    assign stat.lo_lt_hi   = (lo_reg < hi_reg);
    assign stat.lo_zero    = (lo_reg == '0);

    assign result.status      = status_reg;
    assign result.hit_index   = idx_reg;
    assign result.hit_offset  = off_reg;
    assign result.hit_info    = hinfo_reg;
    assign result.entry_total = TOTAL_W'(fill_reg);

endmodule

// ===== rtl/sotfl_ctrl.sv =====
// ----------------------------------------------------------------------------
// sotfl_ctrl
// Command sequencer: add, insertion-sort seal, binary-search lookup, clear.
// ----------------------------------------------------------------------------
module sotfl_ctrl
    import sotfl_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  cmd_t       cmd,
    input  dp_status_t stat,
    output dp_cmd_t    ctl,
    output logic       busy,
    output logic       done
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_ADD,
        S_CLEAR,
        S_SEAL_INIT,
        S_SORT_TEST,
        S_SORT_CAP,
        S_SORT_STEP,
        S_SORT_CMP,
        S_LK_INIT,
        S_LK_LOOP,
        S_LK_CMP,
        S_LK_HIT
    } state_t;

    state_t state_reg, state_next;
    logic   done_reg, done_next;

    always_comb
    begin
        state_next  = state_reg;
        done_next   = 1'b0;
        ctl.op      = OP_NONE;
        ctl.lk_hit  = 1'b0;
        ctl.lk_miss = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    ctl.op = OP_CAPTURE;
                    case (cmd)
                        CMD_ADD:    state_next = S_ADD;
                        CMD_SEAL:   state_next = S_SEAL_INIT;
                        CMD_LOOKUP: state_next = S_LK_INIT;
                        default:    state_next = S_CLEAR;
                    endcase
                end
            end
            S_ADD:
            begin
                ctl.op     = OP_APPEND;
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            S_CLEAR:
            begin
                ctl.op     = OP_CLEAR;
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            S_SEAL_INIT:
            begin
                ctl.op     = OP_SEAL_INIT;
                state_next = S_SORT_TEST;
            end
            S_SORT_TEST:
            begin
                if (stat.i_lt_fill)
                begin
                    ctl.op     = OP_SORT_RD_I;
                    state_next = S_SORT_CAP;
                end
                else
                begin
                    ctl.op     = OP_SEAL_DONE;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_SORT_CAP:
            begin
                ctl.op     = OP_SORT_CAP;
                state_next = S_SORT_STEP;
            end
            S_SORT_STEP:
            begin
                if (stat.j_zero)
                begin
                    ctl.op     = OP_SORT_PLACE;
                    state_next = S_SORT_TEST;
                end
                else
                begin
                    ctl.op     = OP_SORT_RD_J;
                    state_next = S_SORT_CMP;
                end
            end
            S_SORT_CMP:
            begin
                if (stat.shift)
                begin
                    ctl.op     = OP_SORT_SHIFT;
                    state_next = S_SORT_STEP;
                end
                else
                begin
                    ctl.op     = OP_SORT_PLACE;
                    state_next = S_SORT_TEST;
                end
            end
            S_LK_INIT:
            begin
                if (!stat.sealed)
                begin
                    ctl.op     = OP_LK_UNSEALED;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    ctl.op     = OP_LK_INIT;
                    state_next = stat.hint_valid ? S_LK_CMP : S_LK_LOOP;
                end
            end
            S_LK_LOOP:
            begin
                if (stat.lo_lt_hi)
                begin
                    ctl.op     = OP_LK_RD_MID;
                    state_next = S_LK_CMP;
                end
                else if (stat.lo_zero)
                begin
                    ctl.lk_miss = 1'b1;
                    done_next   = 1'b1;
                    state_next  = S_IDLE;
                end
                else
                begin
                    ctl.op     = OP_LK_FIN_RD;
                    state_next = S_LK_HIT;
                end
            end
            S_LK_CMP:
            begin
                ctl.op     = OP_LK_CMP;
                state_next = S_LK_LOOP;
            end
            S_LK_HIT:
            begin
                ctl.lk_hit = 1'b1;
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;

endmodule

// ===== rtl/sotfl_checker.sv =====
// ----------------------------------------------------------------------------
// sotfl_checker
// Port-level checks of the floor lookup core, bound to the top level.
// ----------------------------------------------------------------------------
module sotfl_checker
    import sotfl_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
) (
    input logic      clk,
    input logic      rst_n,
    input logic      start,
    input logic      busy,
    input logic      done,
    input out_word_t result
);

    a_take_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted word did not make the block busy");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    a_finish_strobes: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("command finished without a result");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.status != ST_OK |->
            result.hit_index == '0 && result.hit_offset == '0 && result.hit_info == '0)
        else $error("hit fields not zero on a non-hit result");

    a_total_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> 32'(result.entry_total) <= TABLE_DEPTH)
        else $error("entry total beyond table depth");

endmodule

bind sorted_offset_table_floor_lookup_core sotfl_checker #(
    .TABLE_DEPTH (TABLE_DEPTH)
) u_sotfl_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);

// ===== tb/sv/tb_sorted_offset_table_floor_lookup_core.sv =====
// ----------------------------------------------------------------------------
// tb_sorted_offset_table_floor_lookup_core
// Drives add, seal, lookup and clear words into the core under varying
// sender gaps, predicts each result with a behavioral table model and
// checks every result word field by field against the oldest expectation.
// ----------------------------------------------------------------------------
module tb_sorted_offset_table_floor_lookup_core;
    timeunit 1ns;
    timeprecision 1ps;
    import sotfl_pkg::*;

    localparam int DEPTH = DEF_TABLE_DEPTH;

    int errors = 0;

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $time);
        errors++;
    endtask

    class table_scoreboard;
        logic [31:0] offsets [DEPTH];
        logic [31:0] infos [DEPTH];
        int          fill;
        bit          sealed;
        int          hint;
        out_word_t   pending [$];
        int          hits;
        int          misses;
        int          fulls;

        function void note_word(in_word_t w);
            out_word_t r;
            int lo;
            int hi;
            int mid;
            logic [31:0] ko;
            logic [31:0] ki;
            r = '0;
            r.status = ST_OK;
            case (w.cmd)
                CMD_ADD:
                begin
                    if (fill >= DEPTH)
                    begin
                        r.status = ST_FULL;
                        fulls++;
                    end
                    else
                    begin
                        offsets[fill] = w.key_offset;
                        infos[fill] = w.entry_info;
                        fill++;
                        sealed = 0;
                    end
                end
                CMD_SEAL:
                begin
                    // stable insertion sort
                    for (int i = 1; i < fill; i++)
                    begin
                        ko = offsets[i];
                        ki = infos[i];
                        mid = i - 1;
                        while (mid >= 0 && offsets[mid] > ko)
                        begin
                            offsets[mid+1] = offsets[mid];
                            infos[mid+1] = infos[mid];
                            mid--;
                        end
                        offsets[mid+1] = ko;
                        infos[mid+1] = ki;
                    end
                    sealed = 1;
                    if (hint >= fill) hint = 0;
                end
                CMD_LOOKUP:
                begin
                    if (!sealed) r.status = ST_UNSEALED;
                    else
                    begin
                        lo = 0;
                        hi = fill;
                        while (lo < hi)
                        begin
                            mid = lo + (hi - lo) / 2;
                            if (offsets[mid] <= w.key_offset) lo = mid + 1;
                            else hi = mid;
                        end
                        if (lo == 0)
                        begin
                            r.status = ST_NOTFOUND;
                            hint = 0;
                            misses++;
                        end
                        else
                        begin
                            hint = lo - 1;
                            r.hit_index = HIT_IDX_W'(lo - 1);
                            r.hit_offset = offsets[lo-1];
                            r.hit_info = infos[lo-1];
                            hits++;
                        end
                    end
                end
                default:
                begin
                    fill = 0;
                    sealed = 0;
                    hint = 0;
                end
            endcase
            r.entry_total = TOTAL_W'(fill);
            pending.push_back(r);
        endfunction

        task check_word(out_word_t got);
            out_word_t want;
            if (pending.size() == 0)
            begin
                report_mismatch("unexpected word", 64'(got.hit_offset), 64'(0));
                return;
            end
            want = pending.pop_front();
            if (got.status !== want.status)
                report_mismatch("status", 64'(got.status), 64'(want.status));
            if (got.hit_index !== want.hit_index)
                report_mismatch("hit_index", 64'(got.hit_index), 64'(want.hit_index));
            if (got.hit_offset !== want.hit_offset)
                report_mismatch("hit_offset", 64'(got.hit_offset), 64'(want.hit_offset));
            if (got.hit_info !== want.hit_info)
                report_mismatch("hit_info", 64'(got.hit_info), 64'(want.hit_info));
            if (got.entry_total !== want.entry_total)
                report_mismatch("entry_total", 64'(got.entry_total),
                                64'(want.entry_total));
        endtask
    endclass

    logic      clk = 0;
    logic      rst_n = 0;
    logic      start = 0;
    logic      busy;
    in_word_t  request = '0;
    logic      done;
    out_word_t result;

    table_scoreboard board = new();
    int idle_pct = 0;
    int words_sent = 0;

    sorted_offset_table_floor_lookup_core dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .request(request), .done(done), .result(result)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && done) board.check_word(result);
    end

    task automatic send_word(input cmd_t c, input logic [31:0] k, input logic [31:0] inf);
        in_word_t w;
        while ($urandom_range(99, 0) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        w.cmd = c;
        w.key_offset = k;
        w.entry_info = inf;
        start <= 1'b1;
        request <= w;
        @(posedge clk);
        while (busy) @(posedge clk);
        board.note_word(w);
        words_sent++;
    endtask

    function automatic logic [31:0] pick_key();
        case ($urandom_range(3, 0))
            0: return $urandom_range(15, 0);
            1: return 32'hFFFF_FFFF - $urandom_range(15, 0);
            2: return $urandom_range(400, 0) * 16;
            default: return $urandom;
        endcase
    endfunction

    task automatic wait_drain();
        start <= 1'b0;
        while (board.pending.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    initial
    begin
        int n;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed
        send_word(CMD_LOOKUP, 0, 0);
        send_word(CMD_SEAL, 0, 0);
        send_word(CMD_LOOKUP, 32'hFFFF_FFFF, 0);
        send_word(CMD_ADD, 100, 32'hFFFF_FFFF);
        send_word(CMD_ADD, 32'hFFFF_FFFF, 32'h0000_0001);
        send_word(CMD_ADD, 0, 32'hA5A5_5A5A);
        send_word(CMD_ADD, 100, 32'h0000_0000);
        send_word(CMD_LOOKUP, 100, 0);
        send_word(CMD_SEAL, 0, 0);
        send_word(CMD_LOOKUP, 0, 0);
        send_word(CMD_LOOKUP, 99, 0);
        send_word(CMD_LOOKUP, 100, 0);
        send_word(CMD_LOOKUP, 32'hFFFF_FFFE, 0);
        send_word(CMD_LOOKUP, 32'hFFFF_FFFF, 0);
        send_word(CMD_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_word(CMD_ADD, 50, 7);
        send_word(CMD_SEAL, 0, 0);
        send_word(CMD_LOOKUP, 49, 0);
        send_word(CMD_LOOKUP, 50, 0);
        send_word(CMD_CLEAR, 0, 0);

        // fill to full with sorted keys so seal stays fast, then overflow
        for (int i = 0; i < DEPTH; i++)
            send_word(CMD_ADD, i * 3, $urandom);
        send_word(CMD_ADD, $urandom, $urandom);
        send_word(CMD_SEAL, 0, 0);
        for (int i = 0; i < 40; i++)
            send_word(CMD_LOOKUP, (i < 20) ? pick_key() : $urandom_range(DEPTH * 3, 0), 0);
        send_word(CMD_CLEAR, 0, 0);

        for (int ph = 0; ph < 4; ph++)
        begin
            idle_pct = (ph == 0) ? 0 : (ph == 1) ? 59 : (ph == 2) ? 22 : 0;
            for (int s = 0; s < 4; s++)
            begin
                n = ($urandom_range(9, 0) == 0) ? $urandom_range(60, 20)
                                                : $urandom_range(12, 0);
                for (int i = 0; i < n; i++)
                    send_word(CMD_ADD, pick_key(), $urandom);
                if ($urandom_range(9, 0) == 0)
                    send_word(cmd_t'($urandom_range(3, 0)), pick_key(), $urandom);
                send_word(CMD_SEAL, 0, 0);
                n = $urandom_range(20, 4);
                for (int i = 0; i < n; i++)
                    send_word(CMD_LOOKUP, pick_key(), $urandom);
                if ($urandom_range(3, 0) == 0) send_word(CMD_CLEAR, $urandom, $urandom);
            end
        end

        wait_drain();
        $display("sent %0d words: %0d hits, %0d misses, %0d adds on a full table",
                 words_sent, board.hits, board.misses, board.fulls);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        #200ms;
        $display("TB_ERROR");
        $finish;
    end
endmodule

// ===== filelist.f =====
rtl/sotfl_pkg.sv
rtl/sotfl_ram.sv
rtl/sotfl_datapath.sv
rtl/sotfl_ctrl.sv
rtl/sorted_offset_table_floor_lookup_core.sv
rtl/sotfl_checker.sv
tb/sv/tb_sorted_offset_table_floor_lookup_core.sv
